// ===== hdl/nis_pkg.sv =====
package nis_pkg;

  // capacity and value width
  localparam int MAX_INTERVALS = 32;
  localparam int VALUE_WIDTH   = 32;
  localparam int VAL_W         = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  // index, count and result position widths
  localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int POS_W = 6;
  localparam int FLD_W = 32;

  // input transaction
  typedef struct packed {
    logic signed [FLD_W-1:0] interval_start;
    logic signed [FLD_W-1:0] interval_end;
    logic                    last_interval;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [POS_W-1:0] query_position;
    logic [POS_W-1:0] next_position;
    logic             found;
    logic             overflow;
    logic             last_result;
  } out_t;

  // query token that walks down the cell chain
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        qpos;
    logic signed [VAL_W-1:0] qend;
    logic                    have;
    logic [IDX_W-1:0]        best;
    logic signed [VAL_W-1:0] best_start;
    logic                    last;
  } tok_t;

  // control shared by all cells
  typedef struct packed {
    logic             load;
    logic             shift;
    logic             adv;
    logic [CNT_W-1:0] cnt;
  } cell_ctl_t;

endpackage

// ===== hdl/nis_cell.sv =====
module nis_cell
  import nis_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [IDX_W-1:0]        idx,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] ld_start,
  input  logic signed [VAL_W-1:0] ld_end,
  input  logic signed [VAL_W-1:0] end_in,
  output logic signed [VAL_W-1:0] end_out,
  input  tok_t                    tok_in,
  output tok_t                    tok_out
);

  logic signed [VAL_W-1:0] start_r;
  logic signed [VAL_W-1:0] end_r;
  tok_t                    tok_r;
  tok_t                    tok_nxt;
  logic                    sel;
  logic                    active;
  logic                    better;

  assign sel    = ctl.load && (ctl.cnt == CNT_W'(idx));
  assign active = CNT_W'(idx) < ctl.cnt;

  // stored start stays put, stored end shifts toward cell zero on injection
  always_ff @(posedge clk) begin
    if (sel) begin
      start_r <= ld_start;
    end
    if (sel) begin
      end_r <= ld_end;
    end else if (ctl.shift) begin
      end_r <= end_in;
    end
  end

  assign end_out = end_r;

  // compare this cell's start against the passing query
  assign better = active && (start_r >= tok_in.qend) &&
                  (!tok_in.have || (start_r < tok_in.best_start));

  always_comb begin
    tok_nxt = tok_in;
    if (better) begin
      tok_nxt.have       = 1'b1;
      tok_nxt.best       = idx;
      tok_nxt.best_start = start_r;
    end
  end

  // token stage register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (ctl.adv) begin
      tok_r.valid <= tok_nxt.valid;
    end
    if (ctl.adv) begin
      tok_r.qpos       <= tok_nxt.qpos;
      tok_r.qend       <= tok_nxt.qend;
      tok_r.have       <= tok_nxt.have;
      tok_r.best       <= tok_nxt.best;
      tok_r.best_start <= tok_nxt.best_start;
      tok_r.last       <= tok_nxt.last;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hdl/next_interval_successor_search.sv =====
// channel  direction  payload  handshake
// in_      input      in_t     in_valid / in_stall
// out_     output     out_t    out_valid / out_stall
//
// Loading accepts one interval per cycle until the last one. After the last interval, one result
// per stored interval comes out: each query walks the whole chain of MAX_INTERVALS cells.
// The input stalls from the last interval until the final result is taken.
// Reset is synchronous, active low; it clears the count, overflow and chain valids.
// A stalled result freezes the whole chain; the last cell's register is the output.
module next_interval_successor_search
  import nis_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic             busy_r;
  logic             busy_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] inj_cnt_r;
  logic [CNT_W-1:0] inj_cnt_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic             in_acc;
  logic             adv;
  logic             inj;
  logic             done;
  cell_ctl_t        ctl;
  tok_t             tok_w [0:MAX_INTERVALS];
  logic signed [VAL_W-1:0] end_w [0:MAX_INTERVALS];
  tok_t             res;

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;

  // chain moves whenever the output register is free or being drained
  assign res       = tok_w[MAX_INTERVALS];
  assign out_valid = res.valid;
  assign adv       = !(res.valid && out_stall);
  assign done      = res.valid && !out_stall && res.last;
  assign inj       = busy_r && (inj_cnt_r < cnt_r) && adv;

  // control state
  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    inj_cnt_nxt = inj_cnt_r;
    ovf_nxt     = ovf_r;
    if (in_acc) begin
      if (cnt_r < CNT_W'(MAX_INTERVALS)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_data.last_interval) begin
        busy_nxt    = 1'b1;
        inj_cnt_nxt = '0;
      end
    end
    if (inj) begin
      inj_cnt_nxt = inj_cnt_r + CNT_W'(1);
    end
    if (done) begin
      busy_nxt    = 1'b0;
      cnt_nxt     = '0;
      inj_cnt_nxt = '0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      inj_cnt_r <= '0;
      ovf_r     <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      cnt_r     <= cnt_nxt;
      inj_cnt_r <= inj_cnt_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // cell control; a full store ignores the load
  assign ctl.load  = in_acc && (cnt_r < CNT_W'(MAX_INTERVALS));
  assign ctl.shift = inj;
  assign ctl.adv   = adv;
  assign ctl.cnt   = cnt_r;

  // query injection at the head of the chain
  always_comb begin
    tok_w[0].valid      = inj;
    tok_w[0].qpos       = inj_cnt_r[IDX_W-1:0];
    tok_w[0].qend       = end_w[0];
    tok_w[0].have       = 1'b0;
    tok_w[0].best       = '0;
    tok_w[0].best_start = '0;
    tok_w[0].last       = (inj_cnt_r + CNT_W'(1)) == cnt_r;
  end

  assign end_w[MAX_INTERVALS] = '0;

  // chain of cells, one per interval slot of the store
  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
    nis_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (IDX_W'(k)),
      .ctl      (ctl),
      .ld_start (in_data.interval_start[VAL_W-1:0]),
      .ld_end   (in_data.interval_end[VAL_W-1:0]),
      .end_in   (end_w[k+1]),
      .end_out  (end_w[k]),
      .tok_in   (tok_w[k]),
      .tok_out  (tok_w[k+1])
    );
  end

  // result formatting
  always_comb begin
    out_data.query_position = POS_W'(res.qpos);
    out_data.next_position  = res.have ? POS_W'(res.best) : '0;
    out_data.found          = res.have;
    out_data.overflow       = ovf_r;
    out_data.last_result    = res.last;
  end

  // results only appear while a set is being answered
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r) else $error("result outside query phase");

  // count never exceeds capacity
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_INTERVALS)) else $error("count above capacity");

  // injected queries never pass the stored count
  a_inj_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    inj_cnt_r <= cnt_r) else $error("injection past count");

  // final result returns the block to loading with an empty store
  a_done_clr: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (!busy_r && cnt_r == '0 && !ovf_r)) else $error("store not cleared");

  // no load is taken while answering
  a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_acc) else $error("load during query phase");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import nis_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 220;
  localparam int DRAIN_CYCLES   = MAX_INTERVALS + 16;
  localparam logic signed [FLD_W-1:0] VMIN = {1'b1, {(FLD_W-1){1'b0}}};
  localparam logic signed [FLD_W-1:0] VMAX = {1'b0, {(FLD_W-1){1'b1}}};

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;
  typedef enum int {VALS_NARROW, VALS_MID, VALS_EDGE, VALS_FULL} value_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // successor predictor state
  logic signed [VAL_W-1:0] load_starts [MAX_INTERVALS];
  logic signed [VAL_W-1:0] load_ends   [MAX_INTERVALS];
  int   load_count   = 0;
  logic load_dropped = 1'b0;
  out_t successor_queue [$];
  out_t expected_result;

  int   error_count   = 0;
  int   quiet_cycles  = 0;
  logic hold_request  = 1'b0;
  logic gaps_on       = 1'b1;
  int   burst_left    = 0;
  int   random_items  = 0;

  next_interval_successor_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // store one accepted interval, answer every query on the last one
  task automatic record_interval(input in_t item);
    out_t res;
    logic have;
    int   best;
    logic signed [VAL_W-1:0] best_start;
    if (load_count < MAX_INTERVALS) begin
      load_starts[load_count] = $signed(item.interval_start[VAL_W-1:0]);
      load_ends[load_count]   = $signed(item.interval_end[VAL_W-1:0]);
      load_count++;
    end else begin
      load_dropped = 1'b1;
    end
    if (item.last_interval) begin
      for (int q = 0; q < load_count; q++) begin
        have       = 1'b0;
        best       = 0;
        best_start = '0;
        // smallest start at or above this end, lowest position on a tie
        for (int j = 0; j < load_count; j++) begin
          if (load_starts[j] >= load_ends[q] && (!have || load_starts[j] < best_start)) begin
            have       = 1'b1;
            best       = j;
            best_start = load_starts[j];
          end
        end
        res.query_position = POS_W'(q);
        res.next_position  = have ? POS_W'(best) : '0;
        res.found          = have;
        res.overflow       = load_dropped;
        res.last_result    = (q + 1 == load_count);
        successor_queue.push_back(res);
      end
      load_count   = 0;
      load_dropped = 1'b0;
    end
  endtask

  // one input transaction, with bursts and random gaps ahead of it
  task automatic send_interval(input in_t item);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    record_interval(item);
  endtask

  // sender rests until every expected result is taken
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (successor_queue.size() != 0) @(posedge clk);
  endtask

  function automatic in_t make_interval(input logic signed [FLD_W-1:0] s,
                                        input logic signed [FLD_W-1:0] e,
                                        input logic last);
    in_t item;
    item.interval_start = s;
    item.interval_end   = e;
    item.last_interval  = last;
    return item;
  endfunction

  function automatic logic signed [FLD_W-1:0] pick_value(input value_mode_t vmode);
    case (vmode)
      VALS_NARROW: return FLD_W'(int'($urandom_range(0, 16)) - 8);
      VALS_MID:    return FLD_W'(int'($urandom_range(0, 2000)) - 1000);
      VALS_EDGE: begin
        case ($urandom_range(0, 5))
          0:       return VMIN;
          1:       return VMAX;
          2:       return VMIN + 1;
          3:       return VMAX - 1;
          4:       return '1;
          default: return '0;
        endcase
      end
      default:     return $urandom;
    endcase
  endfunction

  // one set of intervals, last flag on the final one
  task automatic send_set(input int size, input value_mode_t vmode);
    logic signed [FLD_W-1:0] starts_seen [$];
    in_t item;
    for (int i = 0; i < size; i++) begin
      item.interval_start = pick_value(vmode);
      // ends that hit an existing start exactly exercise the >= boundary
      if (starts_seen.size() > 0 && $urandom_range(0, 2) == 0)
        item.interval_end = starts_seen[$urandom_range(0, starts_seen.size() - 1)];
      else
        item.interval_end = pick_value(vmode);
      item.last_interval = (i == size - 1);
      starts_seen.push_back(item.interval_start);
      send_interval(item);
    end
  endtask

  // extremes, ties, self match, no successor
  task automatic test_directed();
    send_interval(make_interval(VMIN, VMIN, 1'b1));
    send_interval(make_interval(VMAX, VMIN, 1'b1));
    send_interval(make_interval(VMIN, VMAX, 1'b1));
    send_interval(make_interval(5, 10, 1'b0));
    send_interval(make_interval(10, 20, 1'b0));
    send_interval(make_interval(10, 12, 1'b0));
    send_interval(make_interval(20, 21, 1'b0));
    send_interval(make_interval(-3, VMAX, 1'b0));
    send_interval(make_interval(VMAX, VMAX, 1'b0));
    send_interval(make_interval(-100, -3, 1'b1));
    send_interval(make_interval(7, 7, 1'b0));
    send_interval(make_interval(7, 7, 1'b0));
    send_interval(make_interval(7, 7, 1'b1));
    send_interval(make_interval(0, VMIN, 1'b0));
    send_interval(make_interval(-1, VMIN, 1'b0));
    send_interval(make_interval(VMIN, 1, 1'b1));
    send_interval(make_interval(-1, 0, 1'b0));
    send_interval(make_interval(0, -1, 1'b1));
  endtask

  // full store, dropped items, dropped last item
  task automatic test_capacity();
    send_set(MAX_INTERVALS, VALS_NARROW);
    send_set(MAX_INTERVALS + 1, VALS_MID);
    send_set(MAX_INTERVALS + 4, VALS_NARROW);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_hold();
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    send_set(24, VALS_NARROW);
    send_set(10, VALS_MID);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // sender pauses until the block is empty between sets
  task automatic test_drained_pause();
    send_set(5, VALS_MID);
    wait_drained();
    send_set(3, VALS_EDGE);
    wait_drained();
  endtask

  // random sets, mostly small, sometimes full or overflowing
  task automatic test_random_sets();
    int size;
    int pick;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      size = $urandom_range(1, 6);
      else if (pick < 90) size = $urandom_range(7, 16);
      else if (pick < 98) size = $urandom_range(17, MAX_INTERVALS);
      else                size = $urandom_range(MAX_INTERVALS + 1, MAX_INTERVALS + 6);
      gaps_on = ($urandom_range(0, 4) != 0);
      send_set(size, value_mode_t'($urandom_range(0, 3)));
      random_items += size;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  // receiver stall pattern, with a counted hold-off on request
  initial begin : receiver_stall
    stall_mode_t mode;
    int mode_left;
    int hold_left;
    int phase;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
          STALL_PERIODIC: out_stall <= ((phase % 5) < 2);
          default:        out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string field, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
      error_count++;
    end
  endfunction

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (successor_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        expected_result = successor_queue.pop_front();
        check_field("query_position", expected_result.query_position, out_data.query_position);
        check_field("next_position", expected_result.next_position, out_data.next_position);
        check_field("found", expected_result.found, out_data.found);
        check_field("overflow", expected_result.overflow, out_data.overflow);
        check_field("last_result", expected_result.last_result, out_data.last_result);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // reset, tests in turn, final report
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity();
    test_output_hold();
    test_drained_pause();
    test_random_sets();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nis_pkg.sv
hdl/nis_cell.sv
hdl/next_interval_successor_search.sv
verif/tb.sv
